// File: rtl/pip_pkg.sv
// Shared constants, codes and controller/datapath link types for the
// point-in-polygon tester. No dependencies.
package pip_pkg;

  localparam int MAX_VERTICES      = 64;
  localparam int ADDR_W            = $clog2(MAX_VERTICES);
  localparam int CNT_W             = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W           = 16;
  localparam int DIFF_W            = COORD_W + 1;
  localparam int PROD_W            = 2 * DIFF_W;
  localparam int VERT_W            = 2 * COORD_W;
  localparam int COUNT_W           = 7;
  localparam int INDEX_W           = 6;
  localparam int MIN_POLY_VERTICES = 3;

  // Input beat kinds carried on tuser
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic              wr_en;       // store the incoming vertex
    logic              load_point;  // latch the query point
    logic              clear;       // reset the parity bit
    logic              issue;       // read the vertex store this cycle
    logic              first;       // read primes the previous vertex
    logic              last;        // read carries the final edge
    logic [ADDR_W-1:0] addr;
    logic              load_out;    // move the parity into the result register
  } pip_cmd_t;

  typedef struct packed {
    logic done;  // final edge applied to the parity this cycle
  } pip_sts_t;

endpackage

// File: rtl/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pip_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pip_datapath.sv
// Datapath: vertex store, edge pipeline (differences, cross products,
// compare) and the even-odd parity. Depends on pip_pkg and pip_ram.
module pip_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pip_pkg::pip_cmd_t             cmd_i,
  input  logic [pip_pkg::INDEX_W-1:0]   vertex_index_i,
  input  logic [pip_pkg::COORD_W-1:0]   coord_x_i,
  input  logic [pip_pkg::COORD_W-1:0]   coord_y_i,
  output pip_pkg::pip_sts_t             sts_o,
  output logic                          inside_o
);
  import pip_pkg::*;

  logic [COORD_W-1:0] px_q, py_q;
  logic [VERT_W-1:0]  rdata;
  logic [COORD_W-1:0] cur_x, cur_y, prev_x_q, prev_y_q;

  logic rd_v_q, rd_first_q, rd_last_q;

  logic signed [DIFF_W-1:0] s1_a_q, s1_b_q, s1_c_q, s1_d_q;
  logic signed [DIFF_W-1:0] s1_a_d, s1_b_d, s1_c_d, s1_d_d;
  logic                     s1_v_q, s1_last_q, s1_str_q, s1_str_d;

  logic signed [PROD_W-1:0] s2_p1_q, s2_p2_q;
  logic                     s2_v_q, s2_last_q, s2_str_q, s2_dypos_q;

  logic inside_q, left, out_q;

  pip_ram #(
    .Width (VERT_W),
    .Depth (MAX_VERTICES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (ADDR_W'(vertex_index_i)),
    .wdata_i ({coord_y_i, coord_x_i}),
    .raddr_i (cmd_i.addr),
    .rdata_o (rdata)
  );

  assign cur_x = rdata[COORD_W-1:0];
  assign cur_y = rdata[VERT_W-1:COORD_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_point) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
    if (rd_v_q) begin
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
    end
  end

  // Edge (i, i-1): cur is the vertex just read, prev_*_q the one before it
  always_comb begin
    s1_a_d = $signed({px_q[COORD_W-1], px_q}) - $signed({cur_x[COORD_W-1], cur_x});
    s1_b_d = $signed({prev_y_q[COORD_W-1], prev_y_q}) - $signed({cur_y[COORD_W-1], cur_y});
    s1_c_d = $signed({prev_x_q[COORD_W-1], prev_x_q}) - $signed({cur_x[COORD_W-1], cur_x});
    s1_d_d = $signed({py_q[COORD_W-1], py_q}) - $signed({cur_y[COORD_W-1], cur_y});
    s1_str_d = ($signed(cur_y) > $signed(py_q)) != ($signed(prev_y_q) > $signed(py_q));
  end

  always_ff @(posedge clk_i) begin
    s1_a_q   <= s1_a_d;
    s1_b_q   <= s1_b_d;
    s1_c_q   <= s1_c_d;
    s1_d_q   <= s1_d_d;
    s1_str_q <= s1_str_d;
    s2_p1_q    <= s1_a_q * s1_b_q;
    s2_p2_q    <= s1_c_q * s1_d_q;
    s2_str_q   <= s1_str_q;
    s2_dypos_q <= ~s1_b_q[DIFF_W-1];
    if (cmd_i.load_out) begin
      out_q <= inside_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q     <= 1'b0;
      rd_first_q <= 1'b0;
      rd_last_q  <= 1'b0;
      s1_v_q     <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_v_q     <= 1'b0;
      s2_last_q  <= 1'b0;
    end else begin
      rd_v_q     <= cmd_i.issue;
      rd_first_q <= cmd_i.first;
      rd_last_q  <= cmd_i.last;
      s1_v_q     <= rd_v_q & ~rd_first_q;
      s1_last_q  <= rd_last_q;
      s2_v_q     <= s1_v_q;
      s2_last_q  <= s1_last_q;
    end
  end

  // Point lies left of the crossing; the sense flips with the sign of dy
  assign left = s2_dypos_q ? (s2_p1_q < s2_p2_q) : (s2_p1_q > s2_p2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else if (cmd_i.clear) begin
      inside_q <= 1'b0;
    end else if (s2_v_q && s2_str_q && left) begin
      inside_q <= ~inside_q;
    end
  end

  assign sts_o.done = s2_v_q & s2_last_q;
  assign inside_o   = out_q;

endmodule

// File: rtl/pip_ctrl.sv
// Controller: accepts beats, holds the vertex count register, sequences the
// store reads of a query and owns the result valid. Depends on pip_pkg.
module pip_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pip_pkg::COUNT_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [pip_pkg::INDEX_W-1:0]   vertex_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pip_pkg::pip_cmd_t             cmd_o,
  input  pip_pkg::pip_sts_t             sts_i
);
  import pip_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [COUNT_W-1:0] count_q;
  logic [CNT_W-1:0]   n_q, n_d, cnt_q, cnt_d, n_eff, rd_idx;
  logic               out_valid_q, out_valid_d;
  logic               accept;

  // Clamp the count to the store depth
  assign n_eff  = (32'(count_q) > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                     : CNT_W'(count_q);
  assign accept = in_valid_i & (state_q == S_IDLE);
  // First read fetches the last vertex, then slots 0 upwards
  assign rd_idx = (cnt_q == '0) ? (n_q - 1'b1) : (cnt_q - 1'b1);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.addr  = rd_idx[ADDR_W-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == ACT_WRITE) begin
            cmd_o.wr_en = (32'(vertex_index_i) < 32'(MAX_VERTICES));
          end else begin
            cmd_o.load_point = 1'b1;
            cmd_o.clear      = 1'b1;
            n_d              = n_eff;
            cnt_d            = '0;
            state_d = (32'(n_eff) < 32'(MIN_POLY_VERTICES)) ? S_OUT : S_RUN;
          end
        end
      end
      S_RUN: begin
        cmd_o.issue = 1'b1;
        cmd_o.first = (cnt_q == '0);
        cmd_o.last  = (cnt_q == n_q);
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == n_q) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts_i.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/point_in_polygon_test.sv
// Top level of the even-odd point-in-polygon tester.
// Depends on pip_pkg, pip_ctrl and pip_datapath.
//
// Usage:
//   The slave stream carries one beat per item; tuser says what it is: a
//   vertex write (stored at vertex_index, no result) or a point query (one
//   result beat on the master stream, inside flag in tdata bit 0). The
//   polygon is the first vertex_count stored vertices (at most 64), set
//   through cfg_we_i/cfg_wdata_i while the block is idle; fewer than three
//   vertices always answer outside.
// Timing:
//   Vertex writes stream at one beat per cycle while no query runs. A
//   query with n vertices reads the vertex store n+1 times, one read a
//   cycle, then drains a three-stage edge pipeline before the result turns
//   valid; no beat is taken meanwhile, and the input is ready again in the
//   same cycle as the result. Fewer than three vertices skip the reads.
// Reset and stall:
//   rst_ni clears the count register, the controller and the result valid;
//   the vertex store is undefined until written. A held result delays only
//   the next query's completion, which then holds off the input.
module point_in_polygon_test (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pip_pkg::COUNT_W-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [39:0]                   s_axis_tdata,  // vertex_index[5:0], coord_x[21:6],
                                                       // coord_y[37:22], zero pad
  input  logic [0:0]                    s_axis_tuser,  // action[0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata   // inside_res[0], zero pad
);
  import pip_pkg::*;

  pip_cmd_t cmd;
  pip_sts_t sts;
  logic     inside_flag;

  pip_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .action_i       (s_axis_tuser[0]),
    .vertex_index_i (s_axis_tdata[INDEX_W-1:0]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  pip_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .vertex_index_i (s_axis_tdata[INDEX_W-1:0]),
    .coord_x_i      (s_axis_tdata[INDEX_W +: COORD_W]),
    .coord_y_i      (s_axis_tdata[INDEX_W+COORD_W +: COORD_W]),
    .sts_o          (sts),
    .inside_o       (inside_flag)
  );

  assign m_axis_tdata = {7'b0, inside_flag};

endmodule

// File: tb/point_in_polygon_test_tb.sv
// Self-checking testbench for point_in_polygon_test: loads polygons through the vertex stream,
// fires point queries and checks every inside flag against an even-odd ray-casting predictor.
// Depends on pip_pkg and the point_in_polygon_test RTL only.
module point_in_polygon_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pip_pkg::*;

  localparam int ITEM_TARGET   = 2000;
  localparam int SETTLE_CYCLES = MAX_VERTICES + 16;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_PHASE    = 2;
  localparam int FULL_SPAN     = 32767;
  localparam int OPENING_COUNTS [8] = '{64, 127, 5, 65, 1, 0, 2, 3};

  // Mirror of the vertex store and count register; predicts each query's inside flag.
  class polygon_mirror;
    logic signed [COORD_W-1:0] vx [MAX_VERTICES];
    logic signed [COORD_W-1:0] vy [MAX_VERTICES];
    logic [COUNT_W-1:0]        vertex_count;
    bit                        inside_due [$];
    int                        errors;

    function new();
      vertex_count = '0;
      errors       = 0;
    endfunction

    function void complain(string msg);
      $error("%s", msg);
      errors++;
    endfunction

    function bit ray_parity(longint px, longint py);
      int     n;
      int     j;
      bit     odd;
      longint ax, ay, bx, by, dy, lhs, rhs;
      n   = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
      odd = 1'b0;
      if (n < MIN_POLY_VERTICES) return 1'b0;
      for (int i = 0; i < n; i++) begin
        j  = (i == 0) ? n - 1 : i - 1;
        ax = vx[i];
        ay = vy[i];
        bx = vx[j];
        by = vy[j];
        // only edges straddling the ray can toggle; horizontal ones never do
        if ((ay > py) == (by > py)) continue;
        dy  = by - ay;
        lhs = (px - ax) * dy;
        rhs = (bx - ax) * (py - ay);
        // point left of the crossing: the sense of the compare follows the sign of dy
        if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) odd = !odd;
      end
      return odd;
    endfunction

    function void take_item(logic act, logic [INDEX_W-1:0] idx,
                            logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
      if (act == ACT_WRITE) begin
        vx[idx] = x;
        vy[idx] = y;
      end else begin
        inside_due = {inside_due, ray_parity(x, y)};
      end
    endfunction

    function void check_inside(logic [7:0] beat);
      bit want;
      if (inside_due.size() == 0) begin
        complain($sformatf("inside_res beat with no query outstanding: got %0b", beat[0]));
        return;
      end
      want = inside_due.pop_front();
      if (beat[0] !== want)
        complain($sformatf("inside_res mismatch: expected %0b, actual %0b", want, beat[0]));
    endfunction

    function bit all_clear();
      if (inside_due.size() != 0)
        complain($sformatf("inside_res: %0d expected beats never arrived", inside_due.size()));
      return errors == 0;
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [COUNT_W-1:0] cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [39:0]        s_axis_tdata;
  logic [0:0]         s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [7:0]         m_axis_tdata;

  polygon_mirror board;
  bit            calm_tx;
  bit            calm_rx;
  bit            hold_off_req;
  bit            store_full;
  int            items_sent;

  point_in_polygon_test i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("point_in_polygon_test verification failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] wild_coord();
    logic [31:0] w;
    int          r;
    w = $urandom();
    r = $urandom_range(0, 9);
    if (r == 0) return -16'sd32768;
    if (r == 1) return 16'sd32767;
    return w[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] near_coord(int centre, int span);
    if (span >= FULL_SPAN) return wild_coord();
    return clamp16(centre + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(0, 2);
    if (r < 70) return $urandom_range(3, 12);
    if (r < 88) return $urandom_range(13, 40);
    if (r < 95) return $urandom_range(41, 64);
    return $urandom_range(65, 127);
  endfunction

  // Receiver: random stalls with calm stretches, plus one long hold-off on request.
  initial begin
    int stall_left;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    calm_rx       = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) calm_rx = !calm_rx;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LONG_HOLD;
      end else if (stall_left == 0 && !calm_rx && $urandom_range(0, 3) == 0) begin
        stall_left = idle_span();
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_inside(m_axis_tdata);
  end

  task automatic offer_item(logic act, logic [INDEX_W-1:0] idx,
                            logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    int gap;
    gap = calm_tx ? 0 : idle_span();
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, y, x, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_item(act, idx, x, y);
    items_sent++;
  endtask

  task automatic offer_query(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    offer_item(ACT_QUERY, INDEX_W'($urandom()), x, y);
  endtask

  // Drop valid, wait for every expected beat, then let a last query run out.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.inside_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_count(int n);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n[COUNT_W-1:0];
    @(posedge clk_i);
    board.vertex_count = n[COUNT_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Query point: on a vertex, beside one, within the polygon's spread, or anywhere.
  task automatic random_query(int cx, int cy, int span, int eff);
    int k;
    int r;
    r = $urandom_range(0, 99);
    k = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
    if (eff > 0 && r < 25) begin
      offer_query(board.vx[k], board.vy[k]);
    end else if (eff > 0 && r < 40) begin
      offer_query(clamp16(int'(board.vx[k]) + int'($urandom_range(0, 4)) - 2),
                  clamp16(int'(board.vy[k]) + int'($urandom_range(0, 4)) - 2));
    end else if (r < 85) begin
      offer_query(near_coord(cx, span + 2), near_coord(cy, span + 2));
    end else begin
      offer_query(wild_coord(), wild_coord());
    end
  endtask

  initial begin
    int count;
    int eff;
    int phase;
    int cx, cy, span, scale;
    int nq;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_WRITE;
    hold_off_req  = 1'b0;
    store_full    = 1'b0;
    calm_tx       = 1'b0;
    items_sent    = 0;
    board         = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty polygon, two vertices, full-range square, its triangle, top slot
    offer_query(16'sd0, 16'sd0);
    offer_item(ACT_WRITE, 6'd0, -16'sd32768, -16'sd32768);
    offer_item(ACT_WRITE, 6'd1, 16'sd32767, -16'sd32768);
    offer_item(ACT_WRITE, 6'd2, 16'sd32767, 16'sd32767);
    offer_item(ACT_WRITE, 6'd3, -16'sd32768, 16'sd32767);
    offer_item(ACT_WRITE, 6'd63, -16'sd1, 16'sd0);
    load_count(2);
    offer_query(16'sd0, 16'sd0);
    load_count(4);
    offer_query(16'sd0, 16'sd0);
    offer_query(-16'sd32768, 16'sd0);
    offer_query(16'sd32767, 16'sd0);
    offer_query(16'sd0, -16'sd32768);
    offer_query(16'sd0, 16'sd32767);
    offer_query(-16'sd32768, -16'sd32768);
    offer_query(16'sd32767, 16'sd32767);
    offer_query(-16'sd1, -16'sd1);
    load_count(3);
    offer_query(16'sd0, 16'sd0);
    offer_query(16'sd1, 16'sd0);
    offer_query(16'sd0, 16'sd1);
    offer_query(16'sd16384, -16'sd16384);

    // random phases: each loads a polygon into slots 0..eff-1, then queries it
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      count = (phase < 8) ? OPENING_COUNTS[phase] : pick_count();
      load_count(count);
      calm_tx = ($urandom_range(0, 3) == 0);
      eff     = (count > MAX_VERTICES) ? MAX_VERTICES : count;
      scale   = $urandom_range(0, 9);
      if (scale < 4) begin
        span = 6;
        cx   = $urandom_range(0, 60000) - 30000;
        cy   = $urandom_range(0, 60000) - 30000;
      end else if (scale < 7) begin
        span = 1000;
        cx   = $urandom_range(0, 40000) - 20000;
        cy   = $urandom_range(0, 40000) - 20000;
      end else begin
        span = FULL_SPAN;
        cx   = 0;
        cy   = 0;
      end
      if (phase == HOLD_PHASE) hold_off_req = 1'b1;
      for (int k = 0; k < eff; k++) begin
        // once every slot holds a vertex, a query may cut into the load
        if (store_full && $urandom_range(0, 9) == 0) random_query(cx, cy, span, k);
        offer_item(ACT_WRITE, k[INDEX_W-1:0], near_coord(cx, span), near_coord(cy, span));
      end
      if (eff == MAX_VERTICES) store_full = 1'b1;
      nq = (phase == HOLD_PHASE) ? 30 : $urandom_range(4, 24);
      repeat (nq) begin
        if ($urandom_range(0, 11) == 0)
          offer_item(ACT_WRITE, INDEX_W'($urandom_range(0, MAX_VERTICES - 1)),
                     near_coord(cx, span), near_coord(cy, span));
        else
          random_query(cx, cy, span, eff);
      end
      phase++;
    end

    drain();
    if (board.all_clear())
      $display("point_in_polygon_test verification clean");
    else
      $display("point_in_polygon_test verification failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/pip_pkg.sv
rtl/pip_ram.sv
rtl/pip_datapath.sv
rtl/pip_ctrl.sv
rtl/point_in_polygon_test.sv
tb/point_in_polygon_test_tb.sv
